// ===== rtl/assert_macros.svh =====
// assertion macros for the rle8 decoder rtl
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/rle8d_pkg.sv =====
// shared types and constants of the rle8 bitmap stream decoder
// no dependencies
`timescale 1ns / 1ps

package rle8d_pkg;

    // default depth of the event queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // decode phase of the front end
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_DELTA_X = 3'd2,
        PH_DELTA_Y = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    // kind of an emitted event
    typedef enum logic [1:0] {
        EV_RUN   = 2'd0,
        EV_EOL   = 2'd1,
        EV_EOB   = 2'd2,
        EV_DELTA = 2'd3
    } t_kind;

    // escape codes following a zero count byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    // one decoded event
    typedef struct packed {
        t_kind      kind;
        logic [7:0] color_index;
        logic [7:0] run_length;
        logic [7:0] delta_right;
        logic [7:0] delta_down;
    } t_event;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/rle8d_front.sv =====
// front end: accepts stream bytes, tracks the pair/escape phase, pushes events
// depends on rle8d_pkg
`timescale 1ns / 1ps

module rle8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_stream_byte,
    input  logic              i_full,
    output logic              o_push,
    output rle8d_pkg::t_event o_event
);

    rle8d_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_held, n_held;
    logic [7:0]        r_lit_rem, n_lit_rem;
    logic              r_pad, n_pad;
    logic              r_done, n_done;
    logic              w_take;

    // a byte is decoded only on a transfer before end of bitmap
    assign w_take = i_valid && !i_full && !r_done;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_lit_rem = r_lit_rem;
        n_pad     = r_pad;
        n_done    = r_done;
        if (w_take) begin
            unique case (r_phase)
                rle8d_pkg::PH_SECOND: begin
                    n_phase = rle8d_pkg::PH_FIRST;
                    if (r_held == 8'd0) begin
                        unique case (i_stream_byte)
                            rle8d_pkg::ESC_EOL: ;
                            rle8d_pkg::ESC_EOB: n_done = 1'b1;
                            rle8d_pkg::ESC_DELTA: n_phase = rle8d_pkg::PH_DELTA_X;
                            default: begin
                                n_lit_rem = i_stream_byte;
                                n_pad     = i_stream_byte[0];
                                n_phase   = rle8d_pkg::PH_LITERAL;
                            end
                        endcase
                    end
                end
                rle8d_pkg::PH_DELTA_X: begin
                    n_held  = i_stream_byte;
                    n_phase = rle8d_pkg::PH_DELTA_Y;
                end
                rle8d_pkg::PH_DELTA_Y: n_phase = rle8d_pkg::PH_FIRST;
                rle8d_pkg::PH_LITERAL: begin
                    n_lit_rem = r_lit_rem - 8'd1;
                    if (r_lit_rem == 8'd1) begin
                        n_phase = r_pad ? rle8d_pkg::PH_PAD : rle8d_pkg::PH_FIRST;
                        n_pad   = 1'b0;
                    end
                end
                rle8d_pkg::PH_PAD: n_phase = rle8d_pkg::PH_FIRST;
                // first byte of a pair, unused codes too
                default: begin
                    n_held  = i_stream_byte;
                    n_phase = rle8d_pkg::PH_SECOND;
                end
            endcase
        end
    end

    // event generation
    always_comb begin
        o_push  = 1'b0;
        o_event = '0;
        if (w_take) begin
            unique case (r_phase)
                rle8d_pkg::PH_SECOND: begin
                    if (r_held != 8'd0) begin
                        o_push              = 1'b1;
                        o_event.kind        = rle8d_pkg::EV_RUN;
                        o_event.color_index = i_stream_byte;
                        o_event.run_length  = r_held;
                    end else begin
                        unique case (i_stream_byte)
                            rle8d_pkg::ESC_EOL: begin
                                o_push       = 1'b1;
                                o_event.kind = rle8d_pkg::EV_EOL;
                            end
                            rle8d_pkg::ESC_EOB: begin
                                o_push       = 1'b1;
                                o_event.kind = rle8d_pkg::EV_EOB;
                            end
                            default: ;
                        endcase
                    end
                end
                rle8d_pkg::PH_DELTA_Y: begin
                    o_push              = 1'b1;
                    o_event.kind        = rle8d_pkg::EV_DELTA;
                    o_event.delta_right = r_held;
                    o_event.delta_down  = i_stream_byte;
                end
                rle8d_pkg::PH_LITERAL: begin
                    o_push              = 1'b1;
                    o_event.kind        = rle8d_pkg::EV_RUN;
                    o_event.color_index = i_stream_byte;
                    o_event.run_length  = 8'd1;
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rle8d_pkg::PH_FIRST;
            r_held    <= 8'd0;
            r_lit_rem <= 8'd0;
            r_pad     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_lit_rem <= n_lit_rem;
            r_pad     <= n_pad;
            r_done    <= n_done;
        end
    end

endmodule

// ===== rtl/rle8d_queue.sv =====
// short event queue between the front end and the output stage
// depends on rle8d_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rle8d_queue #(
    parameter int DEPTH = rle8d_pkg::QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rle8d_pkg::t_event        i_push_data,
    input  logic                     i_pop,
    output rle8d_pkg::t_event        o_pop_data,
    output rle8d_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rle8d_pkg::t_event r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_status.full)
    `ASSERT_NEVER(a_no_underflow, i_pop && o_status.empty)
    `ASSERT_CLK(a_count_track, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

// ===== rtl/rle8d_back.sv =====
// output stage: pops queued events into the output register
// depends on rle8d_pkg
`timescale 1ns / 1ps

module rle8d_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rle8d_pkg::t_queue_status i_status,
    input  rle8d_pkg::t_event        i_pop_data,
    output logic                     o_pop,
    input  logic                     i_stall,
    output logic                     o_valid,
    output rle8d_pkg::t_event        o_event
);

    logic              r_valid, n_valid;
    rle8d_pkg::t_event r_event;
    logic              w_free;

    // register is free when empty or its event transfers now
    assign w_free = !r_valid || !i_stall;
    assign o_pop  = w_free && !i_status.empty;

    always_comb begin
        n_valid = r_valid;
        if (w_free) begin
            n_valid = o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event <= i_pop_data;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule

// ===== rtl/rle8_bitmap_stream_decoder_core.sv =====
// Decoder for an 8-bit run-length-coded bitmap stream, one byte per transfer.
// Input channel: i_valid / o_stall with i_stream_byte. A byte is taken at an
// edge where i_valid is high and o_stall is low; o_stall rises only when the
// internal event queue is full.
// Output channel: o_valid / i_stall with the event fields. Each byte causes at
// most one event: pixel runs, end of line, end of bitmap and delta moves.
// Bytes that only set up a pair, an escape, a delta or skip a pad give none.
// Each event is written to the queue at the edge taking its byte, then moves
// to the output register. Throughput: one byte per cycle while o_stall is low,
// set by the front end phase update; the back end drains one event per cycle.
// When the receiver stalls, the output register holds its event and the queue
// (QUEUE_DEPTH entries) absorbs further events before input is stalled.
// After end of bitmap, bytes are still taken but dropped until reset.
// Reset (synchronous, active low) returns to the first byte of a pair and
// empties the queue and the output register.
// depends on rle8d_pkg, rle8d_front, rle8d_queue, rle8d_back
`timescale 1ns / 1ps

module rle8_bitmap_stream_decoder_core #(
    parameter int QUEUE_DEPTH = rle8d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_color_index,
    output logic [7:0] o_run_length,
    output logic [7:0] o_delta_right,
    output logic [7:0] o_delta_down
);

    logic                     w_push;
    logic                     w_pop;
    rle8d_pkg::t_event        w_push_data;
    rle8d_pkg::t_event        w_pop_data;
    rle8d_pkg::t_event        w_out_event;
    rle8d_pkg::t_queue_status w_status;

    // byte classification and phase tracking
    rle8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .i_full        (w_status.full),
        .o_push        (w_push),
        .o_event       (w_push_data)
    );

    // event queue
    rle8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_status)
    );

    // output register
    rle8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_event    (w_out_event)
    );

    assign o_stall       = w_status.full;
    assign o_event_kind  = w_out_event.kind;
    assign o_color_index = w_out_event.color_index;
    assign o_run_length  = w_out_event.run_length;
    assign o_delta_right = w_out_event.delta_right;
    assign o_delta_down  = w_out_event.delta_down;

endmodule
